[hdl/kos_pkg.sv]
package kos_pkg;

   // fixed field widths of the query and result
   localparam int KIND_W = 2;
   localparam int OCC_W  = 11;
   localparam int POS_W  = 11;

   // depth of the command queue between front and back
   localparam int CMDQ_DEPTH = 2;

   // request kinds; the fourth code carries no meaning and is dropped
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } cmd_kind_type;

   // control part of a queued command
   typedef struct packed {
      cmd_kind_type       kind;
      logic [OCC_W-1:0]   occurrence;
   } cmd_ctrl_type;

endpackage

[hdl/kth_occurrence_search_top.sv]
// channel   direction  handshake             payload
// req_      in         req_push / req_full   req_kind, req_item_value, req_occurrence
// rsp_      out        rsp_pop / rsp_empty   rsp_position
//
// load and clear leave the command queue once the back end is idle; a query
// scans the store, one stored element per cycle through the single read port
// of the element store
// reset is synchronous and empties the store count, the command queue and the result slot
// a result not yet popped holds the next query, and everything queued
// behind it, at the head of the two-entry command queue; req_full rises once it fills

module kth_occurrence_search_top import kos_pkg::*; #(
   parameter int MAX_ITEMS  = 1024,
   parameter int VALUE_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [VALUE_BITS-1:0]  req_item_value,
   input  logic [OCC_W-1:0]       req_occurrence,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [POS_W-1:0]       rsp_position
);

   logic                  cmd_vld;
   cmd_ctrl_type          cmd_ctrl;
   logic [VALUE_BITS-1:0] cmd_value;
   logic                  cmd_take;

   // accept and classify requests
   kos_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .req_occurrence (req_occurrence),
      .cmd_vld        (cmd_vld),
      .cmd_ctrl       (cmd_ctrl),
      .cmd_value      (cmd_value),
      .cmd_take       (cmd_take)
   );

   // store, scan and report
   kos_back #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_vld      (cmd_vld),
      .cmd_ctrl     (cmd_ctrl),
      .cmd_value    (cmd_value),
      .cmd_take     (cmd_take),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_position (rsp_position)
   );

endmodule

[hdl/kos_front.sv]
module kos_front import kos_pkg::*; #(
   parameter int VALUE_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [VALUE_BITS-1:0]  req_item_value,
   input  logic [OCC_W-1:0]       req_occurrence,
   // command side toward the back end
   output logic                   cmd_vld,
   output cmd_ctrl_type           cmd_ctrl,
   output logic [VALUE_BITS-1:0]  cmd_value,
   input  logic                   cmd_take
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_ctrl_type          q_ctrl_ff  [CMDQ_DEPTH];
   logic [VALUE_BITS-1:0] q_value_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic                  req_xfer;
   logic                  enq;
   logic                  deq;

   // classify: only meaningful kinds are queued, others vanish on transfer
   assign req_full = (fill_ff == CNT_W'(CMDQ_DEPTH));
   assign req_xfer = req_push && !req_full;
   always_comb begin
      enq = 1'b0;
      if (req_xfer) begin
         enq = req_kind inside {KIND_LOAD, KIND_QUERY, KIND_CLEAR};
      end
   end

   assign cmd_vld   = (fill_ff != '0);
   assign cmd_ctrl  = q_ctrl_ff[rd_ptr_ff];
   assign cmd_value = q_value_ff[rd_ptr_ff];
   assign deq       = cmd_vld && cmd_take;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         fill_in = fill_ff + 1'b1;
      end else if (deq && !enq) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (enq) begin
         q_ctrl_ff[wr_ptr_ff].kind       <= cmd_kind_type'(req_kind);
         q_ctrl_ff[wr_ptr_ff].occurrence <= req_occurrence;
         q_value_ff[wr_ptr_ff]           <= req_item_value;
      end
   end

endmodule

[hdl/kos_back.sv]
module kos_back import kos_pkg::*; #(
   parameter int MAX_ITEMS  = 1024,
   parameter int VALUE_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   // command side from the front end
   input  logic                   cmd_vld,
   input  cmd_ctrl_type           cmd_ctrl,
   input  logic [VALUE_BITS-1:0]  cmd_value,
   output logic                   cmd_take,
   // result side
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [POS_W-1:0]       rsp_position
);

   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W  = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
   logic [VALUE_BITS-1:0] rd_data_ff;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic [CNT_W-1:0]      data_idx_ff, data_idx_in;
   logic                  data_vld_ff, data_vld_in;
   logic [OCC_W-1:0]      seen_ff, seen_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [OCC_W-1:0]      want_ff, want_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                  mem_we;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SUM_W-1:0]      pos_sum;
   logic                  is_match;
   logic                  is_last;

   assign rsp_empty    = !rsp_vld_ff;
   assign rsp_position = rsp_pos_ff;
   assign rd_addr      = issue_ff[ADDR_W-1:0];
   assign pos_sum      = SUM_W'(data_idx_ff) + SUM_W'(1);
   assign is_match     = data_vld_ff && (rd_data_ff == key_ff);
   assign is_last      = data_vld_ff && (CNT_W'(data_idx_ff + 1'b1) == count_ff);

   // command execution and scan control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      data_idx_in = data_idx_ff;
      data_vld_in = 1'b0;
      seen_in     = seen_ff;
      key_in      = key_ff;
      want_in     = want_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_pop;
      rsp_pos_in  = rsp_pos_ff;
      cmd_take    = 1'b0;
      mem_we      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_vld) begin
               case (cmd_ctrl.kind)
                  KIND_LOAD: begin
                     cmd_take = 1'b1;
                     if (count_ff < CNT_W'(MAX_ITEMS)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     cmd_take = 1'b1;
                     count_in = '0;
                  end
                  KIND_QUERY: begin
                     // one result slot, so wait until it is free
                     if (!rsp_vld_ff) begin
                        cmd_take = 1'b1;
                        key_in   = cmd_value;
                        want_in  = cmd_ctrl.occurrence;
                        seen_in  = '0;
                        issue_in = '0;
                        if (cmd_ctrl.occurrence == '0 || count_ff == '0) begin
                           rsp_vld_in = 1'b1;
                           rsp_pos_in = '0;
                        end else begin
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                     cmd_take = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one read per cycle while entries remain
            if (issue_ff < count_ff) begin
               issue_in    = issue_ff + 1'b1;
               data_idx_in = issue_ff;
               data_vld_in = 1'b1;
            end
            // compare the element read in the previous cycle
            if (is_match && (OCC_W'(seen_ff + 1'b1) == want_ff)) begin
               state_in    = ST_IDLE;
               data_vld_in = 1'b0;
               rsp_vld_in  = 1'b1;
               rsp_pos_in  = pos_sum[POS_W-1:0];
            end else begin
               if (is_match) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (is_last) begin
                  state_in    = ST_IDLE;
                  data_vld_in = 1'b0;
                  rsp_vld_in  = 1'b1;
                  rsp_pos_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         data_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         data_vld_ff <= data_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      data_idx_ff <= data_idx_in;
      seen_ff     <= seen_in;
      key_ff      <= key_in;
      want_ff     <= want_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= cmd_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[tb/sv/tb_top.sv]
module tb_top import kos_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ITEMS  = 1024;
   localparam int VALUE_BITS = 20;

   // the spare kind code, dropped by the block
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct {
      logic [KIND_W-1:0]     kind;
      logic [VALUE_BITS-1:0] value;
      logic [OCC_W-1:0]      occurrence;
      bit                    hold;
   } request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [VALUE_BITS-1:0] req_item_value = '0;
   logic [OCC_W-1:0]      req_occurrence = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [POS_W-1:0]      rsp_position;

   // stimulus and scoreboard state
   request_type           pending_requests[$];
   logic [POS_W-1:0]      expected_positions[$];
   logic [VALUE_BITS-1:0] stored_values[MAX_ITEMS];
   int                    stored_count = 0;
   bit                    error_seen = 1'b0;
   int unsigned           cycle_count = 0;
   logic                  steady;

   kth_occurrence_search_top #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .req_occurrence (req_occurrence),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_position   (rsp_position)
   );

   // clock
   always #5 clock = ~clock;

   // window with no idling on either side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end
   assign steady = (cycle_count >= 2000 && cycle_count < 4000);

   // position of the k-th stored element equal to value, zero when absent or k is zero
   function automatic logic [POS_W-1:0] kth_position(logic [VALUE_BITS-1:0] value,
                                                    logic [OCC_W-1:0] k);
      int seen;
      seen = 0;
      if (k == 0) return '0;
      for (int i = 0; i < stored_count; i++) begin
         if (stored_values[i] == value) begin
            seen++;
            if (seen == k) return POS_W'(i + 1);
         end
      end
      return '0;
   endfunction

   // update the store copy and queue the expected position of a query
   function automatic void track_request(request_type r);
      case (r.kind)
         KIND_LOAD: begin
            if (stored_count < MAX_ITEMS) begin
               stored_values[stored_count] = r.value;
               stored_count++;
            end
         end
         KIND_QUERY: begin
            expected_positions.push_back(kth_position(r.value, r.occurrence));
         end
         KIND_CLEAR: begin
            stored_count = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void queue_request(logic [KIND_W-1:0] kind,
                                         logic [VALUE_BITS-1:0] value,
                                         logic [OCC_W-1:0] occurrence,
                                         bit hold = 1'b0);
      request_type r;
      r.kind       = kind;
      r.value      = value;
      r.occurrence = occurrence;
      r.hold       = hold;
      pending_requests.push_back(r);
   endfunction

   // request driver
   always @(posedge clock) begin
      request_type sent;
      request_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         // transfer at this edge
         if (req_push && !req_full) begin
            sent.kind       = req_kind;
            sent.value      = req_item_value;
            sent.occurrence = req_occurrence;
            sent.hold       = 1'b0;
            track_request(sent);
         end
         // pick the next item once the current one is gone
         if (!req_push || !req_full) begin
            if (pending_requests.size() == 0 ||
                (pending_requests[0].hold && expected_positions.size() != 0) ||
                (!steady && $urandom_range(99) < 19)) begin
               req_push <= 1'b0;
            end else begin
               nxt = pending_requests.pop_front();
               req_kind       <= nxt.kind;
               req_item_value <= nxt.value;
               req_occurrence <= nxt.occurrence;
               req_push       <= 1'b1;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      logic [POS_W-1:0] want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_positions.size() == 0) begin
               $error("position: no result expected, actual %0d", rsp_position);
               error_seen = 1'b1;
            end else begin
               want = expected_positions.pop_front();
               if (rsp_position !== want) begin
                  $error("position: expected %0d, actual %0d", want, rsp_position);
                  error_seen = 1'b1;
               end
            end
         end
         rsp_pop <= steady || ($urandom_range(99) >= 19);
      end
   end

   // stimulus and end of run
   initial begin
      logic [VALUE_BITS-1:0] fill_value;
      logic [VALUE_BITS-1:0] first_value;
      logic [VALUE_BITS-1:0] pick;
      logic [VALUE_BITS-1:0] pool[3];
      logic [OCC_W-1:0]      k;
      int                    fill_hits;
      int                    queued;
      int                    n;
      int                    queries;

      // directed: empty store, field extremes, every kind
      queue_request(KIND_QUERY, '0, OCC_W'(1));
      queue_request(KIND_LOAD, '0, '0);
      queue_request(KIND_LOAD, '1, '1);
      queue_request(KIND_LOAD, VALUE_BITS'(5), '0);
      queue_request(KIND_LOAD, '1, '0);
      queue_request(KIND_LOAD, VALUE_BITS'(5), '0);
      queue_request(KIND_LOAD, '0, '0);
      queue_request(KIND_QUERY, '1, OCC_W'(1));
      queue_request(KIND_QUERY, '1, OCC_W'(2));
      queue_request(KIND_QUERY, '1, OCC_W'(3));
      queue_request(KIND_QUERY, '1, '0);
      queue_request(KIND_QUERY, VALUE_BITS'(5), '1);
      queue_request(KIND_QUERY, '0, OCC_W'(2));
      queue_request(KIND_QUERY, VALUE_BITS'(5), OCC_W'(1024));
      queue_request(KIND_SPARE, '1, '1);
      queue_request(KIND_QUERY, '0, OCC_W'(1));
      queue_request(KIND_CLEAR, '1, '1, 1'b1);
      queue_request(KIND_QUERY, '0, OCC_W'(1));
      queue_request(KIND_LOAD, VALUE_BITS'(20'hA5A5A), '0);
      queue_request(KIND_LOAD, VALUE_BITS'(20'hA5A5A), '0);
      queue_request(KIND_QUERY, VALUE_BITS'(20'hA5A5A), OCC_W'(2));

      // full store, then loads past capacity
      fill_value  = VALUE_BITS'($urandom);
      first_value = VALUE_BITS'($urandom);
      fill_hits   = 0;
      queue_request(KIND_CLEAR, '0, '0, 1'b1);
      queue_request(KIND_LOAD, first_value, '0);
      for (int i = 1; i < MAX_ITEMS - 1; i++) begin
         if ($urandom_range(9) != 0) begin
            queue_request(KIND_LOAD, fill_value, '0);
            fill_hits++;
         end else begin
            queue_request(KIND_LOAD, VALUE_BITS'($urandom), '0);
         end
      end
      queue_request(KIND_LOAD, fill_value, '0);
      fill_hits++;
      for (int i = 0; i < 3; i++) queue_request(KIND_LOAD, first_value, '0);
      queue_request(KIND_QUERY, fill_value, OCC_W'(fill_hits));
      queue_request(KIND_QUERY, fill_value, OCC_W'(fill_hits + 1));
      queue_request(KIND_QUERY, first_value, OCC_W'(1));
      queue_request(KIND_QUERY, first_value, OCC_W'(2));
      queue_request(KIND_QUERY, fill_value, OCC_W'(1));
      queue_request(KIND_QUERY, fill_value, '1);
      queue_request(KIND_QUERY, VALUE_BITS'($urandom), OCC_W'(1));

      // random arrays: mostly a clear, a run of loads mixed with spare kinds, then several queries
      queued = 0;
      while (queued < 580) begin
         pool[0] = VALUE_BITS'($urandom);
         pool[1] = ($urandom_range(3) == 0) ? '1 : VALUE_BITS'($urandom);
         pool[2] = ($urandom_range(3) == 0) ? '0 : VALUE_BITS'($urandom);
         if (queued == 0 || $urandom_range(9) != 0) begin
            queue_request(KIND_CLEAR, VALUE_BITS'($urandom), OCC_W'($urandom),
                          $urandom_range(14) == 0);
            queued++;
         end
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
               queue_request(KIND_SPARE, VALUE_BITS'($urandom), OCC_W'($urandom));
            end
            pick = ($urandom_range(4) != 0) ? pool[$urandom_range(2)] : VALUE_BITS'($urandom);
            queue_request(KIND_LOAD, pick, OCC_W'($urandom));
            queued++;
         end
         queries = $urandom_range(1, 6);
         for (int i = 0; i < queries; i++) begin
            pick = ($urandom_range(3) != 0) ? pool[$urandom_range(2)] : VALUE_BITS'($urandom);
            case ($urandom_range(9))
               0:       k = OCC_W'($urandom);
               1:       k = '0;
               default: k = OCC_W'($urandom_range(1, n / 3 + 2));
            endcase
            queue_request(KIND_QUERY, pick, k);
            queued++;
         end
      end

      // reset, then wait for the stimulus to drain
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_push) @(posedge clock);
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (MAX_ITEMS + 100) @(posedge clock);
      if (!error_seen) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
